// File: hw/rtl/sus_pkg.sv
// Shared types and codes for the sorted unique set core.
`timescale 1ns / 1ps

package sus_pkg;

  // Fixed field widths of the stream payload
  localparam int unsigned OPERAND_W = 32;
  localparam int unsigned HELD_W    = 5;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;  // 38 payload bits padded to bytes

  // Operation select
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 2'd0,
    FN_DEL_MIN = 2'd1,
    FN_DEL_MAX = 2'd2,
    FN_QUERY   = 2'd3
  } func_t;

  // Result status
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Broadcast update command from the controller to every cell
  typedef struct packed {
    logic ins;    // insert operand at its sorted place
    logic shl;    // shift every entry one cell toward the head
  } cell_ctl_t;

  // Per-cell compare result against the broadcast operand
  typedef struct packed {
    logic lt;     // occupied and holds a value below the operand
    logic eq;     // occupied and holds the operand
  } cell_flags_t;

endpackage

// File: hw/rtl/sus_cell.sv
// One storage cell of the sorted chain: compare against operand, shift or load.
`timescale 1ns / 1ps

module sus_cell
  import sus_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [VALUE_BITS-1:0] operand,
  input  logic                  occ,       // cell index is below the count
  input  logic                  left_lt,   // left neighbor below operand (head: 1)
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic [VALUE_BITS-1:0] right_val, // tail cell feeds back its own value
  output logic [VALUE_BITS-1:0] val,
  output cell_flags_t           flags
);

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;

  assign val = val_r;

  // Signed compare with the broadcast operand
  always_comb begin
    flags.lt = occ && ($signed(val_r) < $signed(operand));
    flags.eq = occ && (val_r == operand);
  end

  // Insert: smaller values stay, the first larger cell loads the operand,
  // the rest take their left neighbor. Delete-min: take the right neighbor.
  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (!flags.lt) begin
        val_nxt = left_lt ? operand : left_val;
      end
    end else if (ctl.shl) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: hw/rtl/sorted_unique_set_core.sv
// Top level of the sorted unique set: cell chain, controller and result register.
`timescale 1ns / 1ps
// Sorted unique set core.
// Holds up to CAPACITY distinct signed values in ascending order in a chain
// of cells. Input beats (in_*) carry the operation in in_tuser and the
// operand in in_tdata: insert, delete smallest, delete largest or query.
// Every input beat yields exactly one result beat (out_*): status in
// out_tuser, removed value, found flag and count held in out_tdata.
// The operand is broadcast to all cells, which compare it in parallel and
// shift or load in the same cycle; the result appears in the cycle after
// the input beat is accepted, and a new beat is accepted every cycle while
// the receiver keeps taking results.
// Throughput is set by the broadcast compare and shift.
// When the receiver stalls, the result stays in the output register and
// in_tready drops until that result is taken.
// Reset (rst_n low, synchronous) empties the set and drops out_tvalid;
// cell contents are not cleared, only the count.
module sorted_unique_set_core
  import sus_pkg::*;
#(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [OPERAND_W-1:0]   in_tdata,   // [31:0] operand
  input  logic [FUNC_W-1:0]      in_tuser,   // [1:0] func
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] removed_value, [32] found,
                                             // [37:33] held_count, [39:38] zero
  output logic [STATUS_W-1:0]    out_tuser   // [1:0] status
);

  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned EXT_W = (VALUE_BITS > OPERAND_W) ? VALUE_BITS : OPERAND_W;

  // Control and result registers
  logic [CW-1:0]         count_r, count_nxt;
  logic                  out_valid_r;
  status_t               status_r, status_nxt;
  logic [OPERAND_W-1:0]  removed_r, removed_nxt;
  logic                  found_r, found_nxt;
  logic [HELD_W-1:0]     held_r;

  // Cell chain signals
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  cell_flags_t           cell_flags [CAPACITY];
  logic [CAPACITY-1:0]   occ;
  logic [CAPACITY-1:0]   eq_vec;
  logic [CAPACITY-1:0]   last_sel;
  cell_ctl_t             ctl;

  logic                  fire;
  func_t                 func;
  logic [EXT_W-1:0]      operand_ext;
  logic [VALUE_BITS-1:0] operand;
  logic                  found, empty, full;
  logic [VALUE_BITS-1:0] last_val;

  // Handshake: accept whenever the result register is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;
  assign func      = func_t'(in_tuser);

  // Sign-extend the operand, then fit it to the stored width
  assign operand_ext = EXT_W'($signed(in_tdata));
  assign operand     = operand_ext[VALUE_BITS-1:0];

  // Occupancy and selection of the tail entry from the count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i]      = CW'(i) < count_r;
      last_sel[i] = (CW'(i + 1) == count_r);
      eq_vec[i]   = cell_flags[i].eq;
    end
  end

  always_comb begin
    last_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      last_val = last_val | (cell_val[i] & {VALUE_BITS{last_sel[i]}});
    end
  end

  assign found = |eq_vec;
  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(CAPACITY));

  // Broadcast command to the chain
  always_comb begin
    ctl.ins = fire && (func == FN_INSERT) && !found && !full;
    ctl.shl = fire && (func == FN_DEL_MIN) && !empty;
  end

  // Cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                  left_lt;
    logic [VALUE_BITS-1:0] left_val;
    logic [VALUE_BITS-1:0] right_val;

    if (g == 0) begin : g_head
      assign left_lt  = 1'b1;
      assign left_val = operand;
    end else begin : g_body
      assign left_lt  = cell_flags[g-1].lt;
      assign left_val = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_val = cell_val[g];
    end else begin : g_inner
      assign right_val = cell_val[g+1];
    end

    sus_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .operand  (operand),
      .occ      (occ[g]),
      .left_lt  (left_lt),
      .left_val (left_val),
      .right_val(right_val),
      .val      (cell_val[g]),
      .flags    (cell_flags[g])
    );
  end

  // Result and count update
  always_comb begin
    count_nxt   = count_r;
    status_nxt  = ST_DONE;
    removed_nxt = '0;
    found_nxt   = 1'b0;
    case (func)
      FN_INSERT: begin
        found_nxt = found;
        if (found) begin
          status_nxt = ST_DUP;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      FN_DEL_MIN: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          removed_nxt = OPERAND_W'(EXT_W'(cell_val[0]));
          count_nxt   = count_r - CW'(1);
        end
      end
      FN_DEL_MAX: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          removed_nxt = OPERAND_W'(EXT_W'(last_val));
          count_nxt   = count_r - CW'(1);
        end
      end
      FN_QUERY: begin
        found_nxt = found;
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r <= count_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      status_r  <= status_nxt;
      removed_r <= removed_nxt;
      found_r   <= found_nxt;
      held_r    <= HELD_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {{(OUT_TDATA_W - OPERAND_W - 1 - HELD_W){1'b0}},
                       held_r, found_r, removed_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the count");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_EMPTY) |-> (held_r == '0 && removed_r == '0))
    else $error("empty status with nonzero count or value");
`endif

endmodule
